// ===== rtl/core/efa_pkg.sv =====
// Package for the Eddington factor accumulator.
// Holds the controller states, divider selects, command and status structs and constants.
// Depends on nothing; every other file of the block imports it.
package efa_pkg;

   localparam int MAX_ORDINATES_DEF = 256;

   // Fixed-point constants.
   localparam logic [33:0] ONE_Q16 = 34'd65536;

   // Restoring division over an 80-bit dividend: one quotient bit a cycle.
   localparam int DIV_STEPS = 80;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int QUO_W     = 50;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_FW,
      ST_MOM,
      ST_ACC,
      ST_CHECK,
      ST_DLOAD,
      ST_DIV,
      ST_DSTORE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_ZZ,
      SEL_RR,
      SEL_RZ,
      SEL_G
   } sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      logic    prod;
      logic    fw;
      logic    mom;
      logic    acc;
      logic    res_clear;
      logic    mark_zero;
      logic    div_load;
      logic    div_step;
      logic    div_store;
      sel_type sel;
      logic    clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic flux_zero;
      logic err_zero;
   } stat_type;

endpackage

// ===== rtl/core/efa_ctrl.sv =====
// Controller of the Eddington factor accumulator: sequences one ordinate
// through the datapath and runs the divisions of a cell. Depends on efa_pkg.
module efa_ctrl #(
   parameter int MAX_ORDINATES = efa_pkg::MAX_ORDINATES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              last_ordinate,
   input  efa_pkg::stat_type stat,
   output efa_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);
   import efa_pkg::*;

   localparam int CNT_W = $clog2(MAX_ORDINATES + 1);

   state_type          state_ff, state_in;
   sel_type            sel_ff, sel_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               last_ff, last_in;

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_ZZ;
         count_ff <= '0;
         step_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      last_in   = last_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               last_in  = last_ordinate;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_FW;
         end
         ST_FW: begin
            cmd.fw   = 1'b1;
            state_in = ST_MOM;
         end
         ST_MOM: begin
            cmd.mom  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Ordinates beyond the limit are dropped.
            if (count_ff < CNT_W'(MAX_ORDINATES)) begin
               cmd.acc  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = last_ff ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            cmd.res_clear = 1'b1;
            sel_in        = SEL_ZZ;
            if (stat.flux_zero) begin
               cmd.mark_zero = 1'b1;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DSTORE;
            end
         end
         ST_DSTORE: begin
            cmd.div_store = 1'b1;
            unique case (sel_ff)
               SEL_ZZ: begin
                  sel_in   = SEL_RR;
                  state_in = ST_DLOAD;
               end
               SEL_RR: begin
                  sel_in   = SEL_RZ;
                  state_in = ST_DLOAD;
               end
               SEL_RZ: begin
                  // The radial factor is already stored here.
                  if (stat.err_zero) begin
                     cmd.mark_zero = 1'b1;
                     state_in      = ST_OUT;
                  end else begin
                     sel_in   = SEL_G;
                     state_in = ST_DLOAD;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = 1'b1;
            count_in  = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/efa_dp.sv =====
// Datapath of the Eddington factor accumulator: products, saturating moment
// sums and a shared bit-serial divider. Depends on efa_pkg.
module efa_dp (
   input  logic                clock,
   input  logic                reset,
   input  efa_pkg::cmd_type    cmd,
   output efa_pkg::stat_type   stat,
   input  logic [23:0]         req_flux_a,
   input  logic [23:0]         req_flux_b,
   input  logic [15:0]         req_vol_a,
   input  logic [15:0]         req_vol_b,
   input  logic                req_blend,
   input  logic signed [15:0]  req_mu,
   input  logic signed [15:0]  req_xi,
   input  logic [15:0]         req_weight,
   output logic signed [31:0]  rsp_ezz,
   output logic signed [31:0]  rsp_err,
   output logic signed [31:0]  rsp_erz,
   output logic signed [31:0]  rsp_g_factor,
   output logic                rsp_zero_flux
);
   import efa_pkg::*;

   // Captured input word.
   logic [23:0]        fa_ff, fb_ff;
   logic [15:0]        va_ff, vb_ff, w_ff;
   logic               blend_ff;
   logic signed [15:0] mu_ff, xi_ff;

   // Product stages.
   logic [39:0]        pa_ff, pb_ff;
   logic [30:0]        czz_ff, crr_ff, crz_ff;
   logic               rzneg_ff;
   logic [56:0]        fw_ff;
   logic [57:0]        hzz_ff, hrr_ff, hrz_ff;
   logic [60:0]        lzz_ff, lrr_ff, lrz_ff;

   // Accumulators.
   logic [63:0]        fsum_ff;
   logic signed [63:0] zz_ff, rr_ff, rz_ff;

   // Divider.
   logic [79:0]        dvd_ff;
   logic [63:0]        dsr_ff, rem_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic               big_ff, neg_ff;

   // Results.
   logic signed [31:0] ezz_ff, err_ff, erz_ff, g_ff;
   logic               zero_ff;

   logic signed [31:0] mxr;
   logic [40:0]        f_val;
   logic [57:0]        r_zz, r_rr, r_rz;
   logic signed [63:0] t_zz, t_rr, t_rz;
   logic [64:0]        fsum_wide;
   logic signed [63:0] zz_in, rr_in, rz_in;
   logic signed [63:0] mom_sel;
   logic [63:0]        mom_mag;
   logic signed [33:0] num;
   logic [33:0]        num_mag;
   logic [31:0]        err_mag;
   logic [64:0]        trial;
   logic               ge;
   logic [31:0]        ratio_val;
   logic [31:0]        res31;
   logic signed [51:0] gq, gv;

   function automatic logic signed [63:0] sat_add(
      input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add = s;
      end
   endfunction

   // Mixed cosine product, kept as sign and magnitude.
   assign mxr = mu_ff * xi_ff;

   // Effective flux: one flux, or the volume-weighted pair.
   assign f_val = blend_ff ? ({1'b0, pa_ff} + {1'b0, pb_ff}) : {17'd0, fa_ff};

   // Moment terms: high part times cosine plus the shifted low part.
   assign r_zz = hzz_ff + {27'd0, lzz_ff[60:30]};
   assign r_rr = hrr_ff + {27'd0, lrr_ff[60:30]};
   assign r_rz = hrz_ff + {27'd0, lrz_ff[60:30]};
   assign t_zz = signed'({6'd0, r_zz});
   assign t_rr = signed'({6'd0, r_rr});
   assign t_rz = rzneg_ff ? -signed'({6'd0, r_rz}) : signed'({6'd0, r_rz});

   assign fsum_wide = {1'b0, fsum_ff} + {8'd0, fw_ff};
   assign zz_in     = sat_add(zz_ff, t_zz);
   assign rr_in     = sat_add(rr_ff, t_rr);
   assign rz_in     = sat_add(rz_ff, t_rz);

   // Divider operands.
   always_comb begin
      case (cmd.sel)
         SEL_ZZ:  mom_sel = zz_ff;
         SEL_RR:  mom_sel = rr_ff;
         default: mom_sel = rz_ff;
      endcase
   end
   assign mom_mag = mom_sel[63] ? (64'd0 - mom_sel) : mom_sel;
   assign num     = 34'(err_ff) + 34'(ezz_ff) - signed'(ONE_Q16);
   assign num_mag = num[33] ? (34'd0 - num) : num;
   assign err_mag = err_ff[31] ? (32'd0 - err_ff) : err_ff;

   // One restoring step.
   assign trial = {rem_ff, dvd_ff[79]};
   assign ge    = (trial >= {1'b0, dsr_ff});

   // Ratio quotient to Q16.16 with saturation.
   assign res31 = {1'b0, quo_ff[30:0]};
   always_comb begin
      if (big_ff || (|quo_ff[QUO_W-1:31])) begin
         ratio_val = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         ratio_val = neg_ff ? (32'd0 - res31) : res31;
      end
   end

   // G factor: one plus the signed quotient, saturated.
   assign gq = neg_ff ? -signed'({2'd0, quo_ff}) : signed'({2'd0, quo_ff});
   assign gv = gq + 52'sd65536;

   // Input capture and product stages.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fa_ff    <= req_flux_a;
         fb_ff    <= req_flux_b;
         va_ff    <= req_vol_a;
         vb_ff    <= req_vol_b;
         blend_ff <= req_blend;
         mu_ff    <= req_mu;
         xi_ff    <= req_xi;
         w_ff     <= req_weight;
      end
      if (cmd.prod) begin
         pa_ff    <= va_ff * fa_ff;
         pb_ff    <= vb_ff * fb_ff;
         czz_ff   <= 31'(xi_ff * xi_ff);
         crr_ff   <= 31'(mu_ff * mu_ff);
         crz_ff   <= mxr[31] ? 31'(32'd0 - mxr) : mxr[30:0];
         rzneg_ff <= mxr[31];
      end
      if (cmd.fw) begin
         fw_ff <= 57'(f_val * w_ff);
      end
      if (cmd.mom) begin
         hzz_ff <= fw_ff[56:30] * czz_ff;
         hrr_ff <= fw_ff[56:30] * crr_ff;
         hrz_ff <= fw_ff[56:30] * crz_ff;
         lzz_ff <= fw_ff[29:0] * czz_ff;
         lrr_ff <= fw_ff[29:0] * crr_ff;
         lrz_ff <= fw_ff[29:0] * crz_ff;
      end
   end

   // Saturating accumulators, cleared once a result has gone out.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fsum_ff <= '0;
         zz_ff   <= '0;
         rr_ff   <= '0;
         rz_ff   <= '0;
      end else if (cmd.acc) begin
         fsum_ff <= fsum_wide[64] ? {64{1'b1}} : fsum_wide[63:0];
         zz_ff   <= zz_in;
         rr_ff   <= rr_in;
         rz_ff   <= rz_in;
      end
   end

   // Shared divider: load and step; the store is in the result registers.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= '0;
         big_ff <= 1'b0;
         if (cmd.sel == SEL_G) begin
            dvd_ff <= {30'd0, num_mag, 16'd0};
            dsr_ff <= {32'd0, err_mag};
            neg_ff <= num[33] ^ err_ff[31];
         end else begin
            dvd_ff <= {mom_mag, 16'd0};
            dsr_ff <= fsum_ff;
            neg_ff <= mom_sel[63];
         end
      end else if (cmd.div_step) begin
         rem_ff <= ge ? 64'(trial - {1'b0, dsr_ff}) : trial[63:0];
         dvd_ff <= {dvd_ff[78:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         big_ff <= big_ff | quo_ff[QUO_W-1];
      end
   end

   // Result registers; a zero flux sum is flagged in the same cycle as the clear.
   always_ff @(posedge clock) begin
      if (cmd.res_clear) begin
         ezz_ff  <= '0;
         err_ff  <= '0;
         erz_ff  <= '0;
         g_ff    <= '0;
         zero_ff <= cmd.mark_zero;
      end else begin
         if (cmd.mark_zero) begin
            zero_ff <= 1'b1;
         end
         if (cmd.div_store) begin
            case (cmd.sel)
               SEL_ZZ: ezz_ff <= ratio_val;
               SEL_RR: err_ff <= ratio_val;
               SEL_RZ: erz_ff <= ratio_val;
               default: begin
                  if (gv[51:31] != {21{gv[51]}}) begin
                     g_ff <= gv[51] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                  end else begin
                     g_ff <= gv[31:0];
                  end
               end
            endcase
         end
      end
   end

   assign stat.flux_zero = (fsum_ff == 64'd0);
   assign stat.err_zero  = (err_ff == 32'sd0);

   assign rsp_ezz       = ezz_ff;
   assign rsp_err       = err_ff;
   assign rsp_erz       = erz_ff;
   assign rsp_g_factor  = g_ff;
   assign rsp_zero_flux = zero_ff;

endmodule

// ===== rtl/core/eddington_factor_accumulator.sv =====
// Eddington factor accumulator, top level: controller plus datapath.
// An ordinate passes through capture, three registered multiply stages and accumulate.
// A closing ordinate adds a check state, an output state, the three ratio divisions on the shared bit-serial
// divider unless the flux sum is zero, and the G factor division unless the radial factor is zero.
// Synchronous reset clears the controller, ordinate count and moment sums; rsp_ is not stalled.
module eddington_factor_accumulator #(
   parameter int MAX_ORDINATES = efa_pkg::MAX_ORDINATES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_flux_a,
   input  logic [23:0]        req_flux_b,
   input  logic [15:0]        req_vol_a,
   input  logic [15:0]        req_vol_b,
   input  logic               req_blend,
   input  logic signed [15:0] req_mu,
   input  logic signed [15:0] req_xi,
   input  logic [15:0]        req_weight,
   input  logic               req_last_ordinate,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_ezz,
   output logic signed [31:0] rsp_err,
   output logic signed [31:0] rsp_erz,
   output logic signed [31:0] rsp_g_factor,
   output logic               rsp_zero_flux
);
   import efa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   efa_ctrl #(
      .MAX_ORDINATES(MAX_ORDINATES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .last_ordinate(req_last_ordinate),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid)
   );

   // Arithmetic.
   efa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_flux_a   (req_flux_a),
      .req_flux_b   (req_flux_b),
      .req_vol_a    (req_vol_a),
      .req_vol_b    (req_vol_b),
      .req_blend    (req_blend),
      .req_mu       (req_mu),
      .req_xi       (req_xi),
      .req_weight   (req_weight),
      .rsp_ezz      (rsp_ezz),
      .rsp_err      (rsp_err),
      .rsp_erz      (rsp_erz),
      .rsp_g_factor (rsp_g_factor),
      .rsp_zero_flux(rsp_zero_flux)
   );

endmodule

// ===== dv/eddington_factor_accumulator_test.sv =====
// Self-checking testbench for the Eddington factor accumulator.
// Needs efa_pkg and eddington_factor_accumulator; it predicts every result word in-line.
`timescale 1ns / 100ps

module eddington_factor_accumulator_test;

   import efa_pkg::*;

   localparam int ORD_LIMIT = MAX_ORDINATES_DEF;
   localparam longint unsigned LOW30 = 64'h3FFF_FFFF;
   localparam longint ONE_FIX = 65536;
   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [23:0]        flux_a;
      logic [23:0]        flux_b;
      logic [15:0]        vol_a;
      logic [15:0]        vol_b;
      logic               blend;
      logic signed [15:0] mu;
      logic signed [15:0] xi;
      logic [15:0]        weight;
      logic               last;
   } ordinate_type;

   typedef struct packed {
      logic signed [31:0] ezz;
      logic signed [31:0] err;
      logic signed [31:0] erz;
      logic signed [31:0] g_factor;
      logic               zero_flux;
   } factors_type;

   // One row of the directed table: an ordinate and, where obvious, its typed result.
   typedef struct packed {
      ordinate_type ord;
      logic         known;
      factors_type  res;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [23:0]        req_flux_a;
   logic [23:0]        req_flux_b;
   logic [15:0]        req_vol_a;
   logic [15:0]        req_vol_b;
   logic               req_blend;
   logic signed [15:0] req_mu;
   logic signed [15:0] req_xi;
   logic [15:0]        req_weight;
   logic               req_last_ordinate;
   logic               rsp_valid;
   logic signed [31:0] rsp_ezz;
   logic signed [31:0] rsp_err;
   logic signed [31:0] rsp_erz;
   logic signed [31:0] rsp_g_factor;
   logic               rsp_zero_flux;

   // Predictor state: the cell's running sums and ordinate count.
   longint unsigned weighted_flux;
   longint          zz_sum;
   longint          rr_sum;
   longint          rz_sum;
   int              cell_count;

   factors_type pending_factors[$];
   int          fail_count = 0;
   int          idle_pct = 0;

   eddington_factor_accumulator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_flux_a(req_flux_a), .req_flux_b(req_flux_b),
      .req_vol_a(req_vol_a), .req_vol_b(req_vol_b), .req_blend(req_blend),
      .req_mu(req_mu), .req_xi(req_xi), .req_weight(req_weight),
      .req_last_ordinate(req_last_ordinate),
      .rsp_valid(rsp_valid), .rsp_ezz(rsp_ezz), .rsp_err(rsp_err), .rsp_erz(rsp_erz),
      .rsp_g_factor(rsp_g_factor), .rsp_zero_flux(rsp_zero_flux)
   );

   // Clock with a 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table: extremes, blending, zero sums and the plain unit case.
   table_row_type directed_rows [14] = '{
      // Zero flux closes a cell with a zero flux sum.
      '{'{24'd0, 24'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'hFFFF, 1'b1},
        1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1}},
      // Flux present but both cosines zero: the radial factor is zero.
      '{'{24'd256, 24'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'hFFFF, 1'b1},
        1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1}},
      // Both cosines at minus one: every factor is one and G is two.
      '{'{24'hFFFFFF, 24'd0, 16'd0, 16'd0, 1'b0, -16'sd32768, -16'sd32768, 16'hFFFF, 1'b1},
        1'b1, '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd131072, 1'b0}},
      '{'{24'd1, 24'd0, 16'd0, 16'd0, 1'b0, 16'sd32767, -16'sd32768, 16'd1, 1'b1},
        1'b0, '0},
      // Blended cell with the largest volumes, a zero volume sum and mixed blend.
      '{'{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'sd12345, -16'sd20000,
          16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'd0, 1'b1, 16'sd32767, 16'sd32767, 16'hFFFF, 1'b0},
        1'b0, '0},
      '{'{24'h000100, 24'hABCDEF, 16'd3, 16'hFFFF, 1'b1, -16'sd1, 16'sd1, 16'h8000, 1'b0},
        1'b0, '0},
      '{'{24'h123456, 24'd0, 16'd0, 16'd0, 1'b0, -16'sd16384, 16'sd23170, 16'h5555, 1'b1},
        1'b0, '0},
      '{'{24'd0, 24'hFFFFFF, 16'd0, 16'hFFFF, 1'b1, 16'sd32767, 16'sd0, 16'hAAAA, 1'b0},
        1'b0, '0},
      '{'{24'hFFFFFF, 24'd0, 16'hFFFF, 16'd0, 1'b1, 16'sd0, -16'sd32768, 16'h0001, 1'b1},
        1'b0, '0},
      '{'{24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 1'b0, 16'sd1, -16'sd1, 16'hFFFF, 1'b0},
        1'b0, '0},
      '{'{24'h000001, 24'd0, 16'd0, 16'd0, 1'b0, -16'sd32768, 16'sd32767, 16'd0, 1'b1},
        1'b0, '0},
      '{'{24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 1'b1, 16'sd300, 16'sd32000, 16'h7FFF,
          1'b0}, 1'b0, '0},
      '{'{24'h00FF00, 24'h00FF00, 16'd1, 16'd1, 1'b1, -16'sd32000, 16'sd100, 16'hFFFF, 1'b1},
        1'b0, '0}
   };

   function automatic longint signed_sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return S64_MAX;
      if (b < 0 && s > a) return S64_MIN;
      return s;
   endfunction

   // Scaled moment term, formed on the magnitude of the Q2.30 cosine product.
   function automatic longint scaled_moment(longint unsigned fw, longint c);
      longint unsigned mag;
      longint unsigned r;
      mag = (c < 0) ? longint'(-c) : c;
      r = (fw >> 30) * mag + (((fw & LOW30) * mag) >> 30);
      return (c < 0) ? -longint'(r) : longint'(r);
   endfunction

   // Q16.16 quotient truncated toward zero and clipped to 32 bits.
   function automatic logic signed [31:0] fixed_ratio(longint mom, longint unsigned total);
      longint unsigned mag;
      longint unsigned q;
      longint unsigned r;
      longint unsigned frac;
      longint unsigned res;
      mag = (mom < 0) ? longint'(-mom) : mom;
      q = mag / total;
      r = mag % total;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         frac = frac << 1;
         if (r >= total - r) begin
            r = r - (total - r);
            frac = frac | 1;
         end else begin
            r = r + r;
         end
      end
      if (q >= 32768) return (mom < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res = (q << 16) | frac;
      if (mom < 0) return 32'(-longint'(res));
      if (res > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      return 32'(res);
   endfunction

   // Adds one ordinate to the predicted sums and closes the cell on the last one.
   function automatic bit accumulate_ordinate(ordinate_type o, output factors_type res);
      longint unsigned f;
      longint unsigned fw;
      longint unsigned s;
      longint mu_l;
      longint xi_l;
      longint num;
      longint gv;
      mu_l = o.mu;
      xi_l = o.xi;
      if (cell_count < ORD_LIMIT) begin
         f = o.blend ? longint'(o.vol_a) * o.flux_a + longint'(o.vol_b) * o.flux_b
                     : longint'(o.flux_a);
         fw = f * o.weight;
         s = weighted_flux + fw;
         weighted_flux = (s < weighted_flux) ? '1 : s;
         zz_sum = signed_sat_add(zz_sum, scaled_moment(fw, xi_l * xi_l));
         rr_sum = signed_sat_add(rr_sum, scaled_moment(fw, mu_l * mu_l));
         rz_sum = signed_sat_add(rz_sum, scaled_moment(fw, mu_l * xi_l));
         cell_count++;
      end
      res = '0;
      if (!o.last) return 1'b0;
      if (weighted_flux == 0) begin
         res.zero_flux = 1'b1;
      end else begin
         res.ezz = fixed_ratio(zz_sum, weighted_flux);
         res.err = fixed_ratio(rr_sum, weighted_flux);
         res.erz = fixed_ratio(rz_sum, weighted_flux);
         if (res.err == 0) begin
            res.zero_flux = 1'b1;
         end else begin
            num = longint'(res.err) + longint'(res.ezz) - ONE_FIX;
            gv = ONE_FIX + (num * ONE_FIX) / longint'(res.err);
            if (gv > 64'sh7FFF_FFFF) gv = 64'sh7FFF_FFFF;
            if (gv < -64'sh8000_0000) gv = -64'sh8000_0000;
            res.g_factor = 32'(gv);
         end
      end
      weighted_flux = 0;
      zz_sum = 0;
      rr_sum = 0;
      rz_sum = 0;
      cell_count = 0;
      return 1'b1;
   endfunction

   // Presents one ordinate, waits until the block is idle and queues any closing result.
   task automatic send_ordinate(ordinate_type o, bit known, factors_type typed);
      factors_type res;
      start <= 1'b1;
      req_flux_a <= o.flux_a;
      req_flux_b <= o.flux_b;
      req_vol_a <= o.vol_a;
      req_vol_b <= o.vol_b;
      req_blend <= o.blend;
      req_mu <= o.mu;
      req_xi <= o.xi;
      req_weight <= o.weight;
      req_last_ordinate <= o.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (accumulate_ordinate(o, res)) pending_factors.push_back(known ? typed : res);
      // Random sender gaps.
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] pick_cosine();
      case ($urandom_range(7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic ordinate_type random_ordinate(bit last, bit heavy);
      ordinate_type o;
      o.flux_a = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom());
      o.flux_b = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom());
      o.vol_a = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom());
      o.vol_b = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom());
      o.blend = 1'($urandom());
      o.mu = pick_cosine();
      o.xi = pick_cosine();
      o.weight = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom());
      o.last = last;
      // Heavy ordinates drive every sum towards saturation.
      if (heavy) begin
         o.flux_a = 24'hFFFFFF;
         o.flux_b = 24'hFFFFFF;
         o.vol_a = 16'hFFFF;
         o.vol_b = 16'hFFFF;
         o.blend = 1'b1;
         o.weight = 16'hFFFF;
         o.mu = -16'sd32768;
         o.xi = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // Result checker: every strobed word is compared with the oldest prediction.
   always @(posedge clock) begin
      factors_type want;
      if (!reset && rsp_valid) begin
         if (pending_factors.size() == 0) begin
            $display("unexpected result word at %0t", $realtime);
            fail_count++;
         end else begin
            want = pending_factors.pop_front();
            if (rsp_ezz !== want.ezz) report_mismatch("ezz", rsp_ezz, want.ezz);
            if (rsp_err !== want.err) report_mismatch("err", rsp_err, want.err);
            if (rsp_erz !== want.erz) report_mismatch("erz", rsp_erz, want.erz);
            if (rsp_g_factor !== want.g_factor)
               report_mismatch("g_factor", rsp_g_factor, want.g_factor);
            if (rsp_zero_flux !== want.zero_flux)
               report_mismatch("zero_flux", rsp_zero_flux, want.zero_flux);
         end
      end
   end

   // Stimulus: reset, the directed table, then three phases of random cells.
   initial begin
      int sent;
      int cell_len;
      int pick;
      bit heavy;
      reset = 1'b1;
      start = 1'b0;
      req_flux_a = '0;
      req_flux_b = '0;
      req_vol_a = '0;
      req_vol_b = '0;
      req_blend = 1'b0;
      req_mu = '0;
      req_xi = '0;
      req_weight = '0;
      req_last_ordinate = 1'b0;
      weighted_flux = 0;
      zz_sum = 0;
      rr_sum = 0;
      rz_sum = 0;
      cell_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_ordinate(directed_rows[i].ord, directed_rows[i].known, directed_rows[i].res);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
         sent = 0;
         while (sent < 660) begin
            pick = $urandom_range(99);
            heavy = (pick < 2);
            // Mostly short cells, some longer, and rare ones past the ordinate limit.
            cell_len = heavy ? $urandom_range(ORD_LIMIT + 1, ORD_LIMIT + 40)
                     : (pick < 20) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < cell_len; k++)
               send_ordinate(random_ordinate(k == cell_len - 1, heavy), 1'b0, '0);
            sent += cell_len;
         end
      end
      start <= 1'b0;

      wait (pending_factors.size() == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("eddington_factor_accumulator_test passed");
      else
         $display("eddington_factor_accumulator_test failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #50ms;
      $display("eddington_factor_accumulator_test failed");
      $finish;
   end

endmodule
